>>> hw/rtl/unsigned_radix_text_formatter_assert.svh
// Assertion macros used by the checker file of the formatter.
`ifndef UNSIGNED_RADIX_TEXT_FORMATTER_ASSERT_SVH
`define UNSIGNED_RADIX_TEXT_FORMATTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define URTF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("formatter assertion failed");

// Next-cycle implication, disabled while reset is high.
`define URTF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("formatter assertion failed");

`endif

>>> hw/rtl/urtf_pkg.sv
// ----------------------------------------------------------------------------
// urtf_pkg
// Types, codes and helpers shared by the unsigned radix text formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package urtf_pkg;

   // Field widths and digit store size.
   localparam int VALUE_W   = 64;
   localparam int DIGITS    = 24;
   localparam int DIG_W     = 4 * DIGITS;
   localparam int NDIG_W    = $clog2(DIGITS + 1);
   localparam int BITCNT_W  = $clog2(VALUE_W);
   localparam int MAX_FIELD_DEFAULT = 64;

   // Radix commands.
   localparam logic [1:0] CMD_DEC  = 2'd0;
   localparam logic [1:0] CMD_OCT  = 2'd1;
   localparam logic [1:0] CMD_HEXL = 2'd2;
   localparam logic [1:0] CMD_HEXU = 2'd3;

   // Size modifiers.
   localparam logic [1:0] SIZE_PLAIN = 2'd0;
   localparam logic [1:0] SIZE_H     = 2'd1;
   localparam logic [1:0] SIZE_L     = 2'd2;

   // ASCII codes.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   typedef struct packed {
      logic [1:0]         command;
      logic [VALUE_W-1:0] value;
      logic [1:0]         size_modifier;
      logic signed [7:0]  field_width;
      logic signed [7:0]  precision;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

   // Controls from the top level to the digit unit.
   typedef struct packed {
      logic               start;
      logic               pop;
      logic [1:0]         command;
      logic [VALUE_W-1:0] value;
   } dig_ctl_type;

   // Status from the digit unit to the top level.
   typedef struct packed {
      logic              done;
      logic [NDIG_W-1:0] ndig;
      logic [3:0]        top;
   } dig_sts_type;

   // ASCII text of one digit in the chosen case.
   function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (nib < 4'd10) begin
         digit_char = CHAR_ZERO + {4'd0, nib};
      end else begin
         digit_char = base + {4'd0, nib} - 8'd10;
      end
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/urtf_digits.sv
// ----------------------------------------------------------------------------
// urtf_digits
// Bit-serial digit extraction: shift-and-add-3 for decimal, direct slicing
// for octal and hex, then a leading-zero strip one digit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module urtf_digits (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire urtf_pkg::dig_ctl_type ctl,
   output urtf_pkg::dig_sts_type     sts
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_NORM = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam int OCT_W = 3 * urtf_pkg::DIGITS;

   logic [1:0]                      state_ff, state_in;
   logic [urtf_pkg::DIG_W-1:0]      dig_ff, dig_in;
   logic [urtf_pkg::VALUE_W-1:0]    val_ff, val_in;
   logic [urtf_pkg::BITCNT_W-1:0]   bit_ff, bit_in;
   logic [urtf_pkg::NDIG_W-1:0]     ndig_ff, ndig_in;
   logic [urtf_pkg::DIG_W-1:0]      adj;
   logic [urtf_pkg::DIG_W-1:0]      oct_load;
   logic [OCT_W-1:0]                oct_src;
   logic [3:0]                      top;

   assign top = dig_ff[urtf_pkg::DIG_W-1 -: 4];

   // Per-digit add-3 correction and the octal regrouping of the value.
   always_comb begin
      oct_src = {{(OCT_W - urtf_pkg::VALUE_W){1'b0}}, ctl.value};
      for (int i = 0; i < urtf_pkg::DIGITS; i++) begin
         adj[4*i +: 4] = (dig_ff[4*i +: 4] >= 4'd5) ? dig_ff[4*i +: 4] + 4'd3
                                                   : dig_ff[4*i +: 4];
         oct_load[4*i +: 4] = {1'b0, oct_src[3*i +: 3]};
      end
   end

   // Sequencer for loading, conversion, stripping and shifting out.
   always_comb begin
      state_in = state_ff;
      dig_in   = dig_ff;
      val_in   = val_ff;
      bit_in   = bit_ff;
      ndig_in  = ndig_ff;
      if (ctl.start) begin
         ndig_in = urtf_pkg::NDIG_W'(urtf_pkg::DIGITS);
         if (ctl.command == urtf_pkg::CMD_DEC) begin
            dig_in   = '0;
            val_in   = ctl.value;
            bit_in   = '1;
            state_in = ST_CONV;
         end else if (ctl.command == urtf_pkg::CMD_OCT) begin
            dig_in   = oct_load;
            state_in = ST_NORM;
         end else begin
            dig_in   = {{(urtf_pkg::DIG_W - urtf_pkg::VALUE_W){1'b0}}, ctl.value};
            state_in = ST_NORM;
         end
      end else begin
         case (state_ff)
            ST_CONV: begin
               dig_in = {adj[urtf_pkg::DIG_W-2:0], val_ff[urtf_pkg::VALUE_W-1]};
               val_in = {val_ff[urtf_pkg::VALUE_W-2:0], 1'b0};
               bit_in = bit_ff - 1'b1;
               if (bit_ff == '0) begin
                  state_in = ST_NORM;
               end
            end
            ST_NORM: begin
               if (ndig_ff == '0 || top != 4'd0) begin
                  state_in = ST_DONE;
               end else begin
                  dig_in  = {dig_ff[urtf_pkg::DIG_W-5:0], 4'd0};
                  ndig_in = ndig_ff - 1'b1;
               end
            end
            ST_DONE: begin
               if (ctl.pop) begin
                  dig_in = {dig_ff[urtf_pkg::DIG_W-5:0], 4'd0};
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dig_ff  <= dig_in;
      val_ff  <= val_in;
      bit_ff  <= bit_in;
      ndig_ff <= ndig_in;
   end

   assign sts.done = (state_ff == ST_DONE);
   assign sts.ndig = ndig_ff;
   assign sts.top  = top;

endmodule

`default_nettype wire

>>> hw/rtl/unsigned_radix_text_formatter.sv
// Flow: decimal runs a bit-serial conversion, octal and hex skip it; the leading
// digit search follows, and the first character then passes the CALC and EMIT
// states and the output register.
// Throughput: one character per cycle once running, while the receiver is ready;
// a new request is taken only when idle, after the last character of an item.
// Reset: synchronous, active high; clears control state only, no clearing pass.
// ----------------------------------------------------------------------------
// unsigned_radix_text_formatter
// Formats one unsigned value as a padded run of ASCII characters.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_radix_text_formatter #(
   parameter int MAX_FIELD = urtf_pkg::MAX_FIELD_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire urtf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output urtf_pkg::rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(MAX_FIELD + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [CNT_W-1:0]        width_ff, width_in;
   logic [CNT_W-1:0]        prec_ff, prec_in;
   logic                    pzero_ff, pzero_in;
   logic                    upper_ff, upper_in;
   logic [CNT_W-1:0]        sp_ff, sp_in;
   logic [CNT_W-1:0]        zr_ff, zr_in;
   logic [CNT_W-1:0]        tot_ff, tot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   urtf_pkg::rsp_type       rsp_data_ff, rsp_data_in;
   logic [urtf_pkg::VALUE_W-1:0] value_cut;
   logic [CNT_W-1:0]        nd, zeros, dz, spaces;
   logic                    accept, out_free;
   urtf_pkg::dig_ctl_type   ctl;
   urtf_pkg::dig_sts_type   sts;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Size truncation of the incoming value.
   always_comb begin
      case (req_data.size_modifier)
         urtf_pkg::SIZE_H: value_cut = {48'd0, req_data.value[15:0]};
         urtf_pkg::SIZE_L: value_cut = req_data.value;
         default:          value_cut = {32'd0, req_data.value[31:0]};
      endcase
   end

   assign ctl.start   = accept;
   assign ctl.command = req_data.command;
   assign ctl.value   = value_cut;
   assign ctl.pop     = (state_ff == ST_EMIT) && out_free && sp_ff == '0 && zr_ff == '0;

   urtf_digits u_digits (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sts   (sts)
   );

   // Padding counts from the digit count, precision and width.
   always_comb begin
      if (sts.ndig == '0 && !pzero_ff) begin
         nd = CNT_W'(1);
      end else begin
         nd = CNT_W'(sts.ndig);
      end
      zeros  = (prec_ff > nd) ? prec_ff - nd : '0;
      dz     = nd + zeros;
      spaces = (width_ff > dz) ? width_ff - dz : '0;
   end

   // Control sequence and character generation.
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      prec_in      = prec_ff;
      pzero_in     = pzero_ff;
      upper_in     = upper_ff;
      sp_in        = sp_ff;
      zr_in        = zr_ff;
      tot_in       = tot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.field_width[7]) begin
                  width_in = '0;
               end else if (int'(req_data.field_width[6:0]) > MAX_FIELD) begin
                  width_in = CNT_W'(MAX_FIELD);
               end else begin
                  width_in = CNT_W'(req_data.field_width[6:0]);
               end
               if (req_data.precision[7]) begin
                  prec_in = '0;
               end else if (int'(req_data.precision[6:0]) > MAX_FIELD) begin
                  prec_in = CNT_W'(MAX_FIELD);
               end else begin
                  prec_in = CNT_W'(req_data.precision[6:0]);
               end
               pzero_in = (req_data.precision == 8'sd0);
               upper_in = (req_data.command == urtf_pkg::CMD_HEXU);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (sts.done) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            sp_in  = spaces;
            zr_in  = zeros;
            tot_in = spaces + dz;
            state_in = (spaces + dz == '0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.last = (tot_ff == CNT_W'(1));
               if (sp_ff != '0) begin
                  rsp_data_in.character = urtf_pkg::CHAR_SPACE;
                  sp_in = sp_ff - 1'b1;
               end else if (zr_ff != '0) begin
                  rsp_data_in.character = urtf_pkg::CHAR_ZERO;
                  zr_in = zr_ff - 1'b1;
               end else begin
                  rsp_data_in.character = urtf_pkg::digit_char(sts.top, upper_ff);
               end
               tot_in = tot_ff - 1'b1;
               if (tot_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      width_ff    <= width_in;
      prec_ff     <= prec_in;
      pzero_ff    <= pzero_in;
      upper_ff    <= upper_in;
      sp_ff       <= sp_in;
      zr_ff       <= zr_in;
      tot_ff      <= tot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/urtf_checker.sv
// ----------------------------------------------------------------------------
// urtf_checker
// Port-level checks on the formatter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "unsigned_radix_text_formatter_assert.svh"

module urtf_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire urtf_pkg::rsp_type rsp_data
);

   logic req_taken, rsp_stall, rsp_mid;

   assign req_taken = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_mid   = rsp_valid && rsp_ready && !rsp_data.last;

   // A stalled result transaction keeps its valid and payload.
   `URTF_ASSERT_NXT(a_rsp_valid_holds, clock, reset, rsp_stall, rsp_valid)
   `URTF_ASSERT_NXT(a_rsp_data_holds, clock, reset, rsp_stall, $stable(rsp_data))

   // A new request is never taken in the cycle after one was taken.
   `URTF_ASSERT_NXT(a_busy_after_req, clock, reset, req_taken, !req_ready)

   // While a run is still going, no new request is taken.
   `URTF_ASSERT_IMP(a_busy_mid_run, clock, reset, rsp_mid, !req_ready)

endmodule

bind unsigned_radix_text_formatter urtf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unsigned radix text formatter. A directed set
// and then random requests are sent. Each request is turned into its padded
// character run in the bench, and every character that leaves the block is
// compared in order with that run.
// ----------------------------------------------------------------------------

module tb_top;
   import urtf_pkg::*;

   localparam int          FIELD_CAP    = MAX_FIELD_DEFAULT;
   localparam int          RANDOM_ITEMS = 110;
   localparam int          HOLD_CYCLES  = 500;
   localparam int          DRAIN_CYCLES = 200;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          REPORT_MAX   = 10;
   localparam logic [1:0]  SIZE_UNUSED  = 2'd3;

   // Tracks the character runs still owed by the block and checks each
   // character against the oldest one.
   class format_checker;
      rsp_type owed_chars[$];
      int      failures;
      string   lower_set = "0123456789abcdef";
      string   upper_set = "0123456789ABCDEF";

      // Builds the character run for one accepted request.
      function void note_request(req_type item);
         logic [63:0] num;
         logic [63:0] radix;
         logic [7:0]  digits[$];
         int          width;
         int          prec;
         int          zeros;
         int          pad;
         int          total;
         int          k;
         rsp_type     ch;
         num = item.value;
         if (item.size_modifier == SIZE_H) begin
            num = {48'd0, num[15:0]};
         end else if (item.size_modifier != SIZE_L) begin
            num = {32'd0, num[31:0]};
         end
         case (item.command)
            CMD_DEC: begin
               radix = 64'd10;
            end
            CMD_OCT: begin
               radix = 64'd8;
            end
            default: begin
               radix = 64'd16;
            end
         endcase
         width = $signed(item.field_width);
         prec  = $signed(item.precision);
         if (width > FIELD_CAP) width = FIELD_CAP;
         if (prec > FIELD_CAP) prec = FIELD_CAP;

         // Digits, most significant first.
         if (num == 64'd0) begin
            if (prec != 0) digits.push_front(CHAR_ZERO);
         end else begin
            while (num != 64'd0) begin
               if (item.command == CMD_HEXU) begin
                  digits.push_front(upper_set[int'(num % radix)]);
               end else begin
                  digits.push_front(lower_set[int'(num % radix)]);
               end
               num = num / radix;
            end
         end
         zeros = (prec > digits.size()) ? prec - digits.size() : 0;
         pad   = width - (digits.size() + zeros);
         if (pad < 0) pad = 0;
         total = pad + zeros + digits.size();

         // Spaces, then zero padding, then the digits.
         for (k = 0; k < total; k++) begin
            if (k < pad) begin
               ch.character = CHAR_SPACE;
            end else if (k < pad + zeros) begin
               ch.character = CHAR_ZERO;
            end else begin
               ch.character = digits[k - pad - zeros];
            end
            ch.last = (k == total - 1);
            owed_chars.push_back(ch);
         end
      endfunction

      // Compares one accepted character with the oldest owed one.
      function void check_char(rsp_type got);
         rsp_type want;
         if (owed_chars.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("Unexpected character: got char=%h last=%b", got.character, got.last);
            end
            return;
         end
         want = owed_chars.pop_front();
         if (got.character !== want.character || got.last !== want.last) begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("Character mismatch: expected char=%h last=%b, got char=%h last=%b",
                        want.character, want.last, got.character, got.last);
            end
         end
      endfunction

      // Anything still owed at the end is a failure.
      function void check_drained();
         if (owed_chars.size() != 0) begin
            failures++;
            if (failures <= REPORT_MAX) begin
               $display("%0d characters never arrived", owed_chars.size());
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   format_checker board;
   int            sent_count;
   int            cycle_count;
   logic          hold_rsp;
   logic          burst_mode;

   unsigned_radix_text_formatter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Clock: 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("** unsigned_radix_text_formatter: FAILED **");
         $finish;
      end
   end

   function automatic req_type make_request(logic [1:0] cmd, logic [63:0] val,
                                            logic [1:0] size, logic [7:0] width,
                                            logic [7:0] prec);
      req_type item;
      item.command       = cmd;
      item.value         = val;
      item.size_modifier = size;
      item.field_width   = width;
      item.precision     = prec;
      return item;
   endfunction

   // Width or precision, mostly small, sometimes saturating or raw.
   function automatic logic [7:0] random_field();
      case ($urandom_range(0, 7))
         0: begin
            return 8'hFF;
         end
         1, 2, 3: begin
            return 8'($urandom_range(0, 24));
         end
         4: begin
            return 8'($urandom_range(0, 2));
         end
         5: begin
            return 8'($urandom_range(25, 64));
         end
         6: begin
            return 8'($urandom_range(65, 127));
         end
         default: begin
            return 8'($urandom);
         end
      endcase
   endfunction

   function automatic req_type random_request();
      logic [63:0] val;
      logic [1:0]  size;
      case ($urandom_range(0, 6))
         0: begin
            val = 64'($urandom_range(0, 20));
         end
         1: begin
            val = 64'd0;
         end
         2: begin
            val = '1;
         end
         3: begin
            val = 64'd1 << $urandom_range(0, 63);
         end
         4: begin
            val = {$urandom, $urandom} >> $urandom_range(0, 63);
         end
         default: begin
            val = {$urandom, $urandom};
         end
      endcase
      size = ($urandom_range(0, 9) == 0) ? SIZE_UNUSED : 2'($urandom_range(0, 2));
      return make_request(2'($urandom_range(0, 3)), val, size, random_field(),
                          random_field());
   endfunction

   // Offers one request after a random gap and waits until it is taken.
   task automatic send_request(req_type item);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
      sent_count++;
   endtask

   // Result side: random stall before each character, plus the long hold.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, 7);
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         while (hold_rsp) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_char(rsp_data);
      end
   end

   // Long receiver hold while requests keep coming, so the block backs up.
   initial begin
      hold_rsp = 1'b0;
      wait (sent_count >= 60);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // Main sequence.
   initial begin
      req_type directed[$];
      board       = new();
      cycle_count = 0;
      sent_count  = 0;
      burst_mode  = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every radix, each corner of the padding rules.
      directed.push_back(make_request(CMD_DEC, 64'd0, SIZE_PLAIN, 8'hFF, 8'hFF));
      directed.push_back(make_request(CMD_DEC, 64'd0, SIZE_PLAIN, 8'hFF, 8'd0));
      directed.push_back(make_request(CMD_OCT, 64'd0, SIZE_L, 8'd5, 8'd0));
      directed.push_back(make_request(CMD_HEXL, '1, SIZE_L, 8'hFF, 8'hFF));
      directed.push_back(make_request(CMD_HEXU, '1, SIZE_L, 8'd20, 8'hFF));
      directed.push_back(make_request(CMD_OCT, '1, SIZE_L, 8'hFF, 8'hFF));
      directed.push_back(make_request(CMD_DEC, '1, SIZE_L, 8'hFF, 8'hFF));
      directed.push_back(make_request(CMD_DEC, '1, SIZE_PLAIN, 8'hFF, 8'hFF));
      directed.push_back(make_request(CMD_HEXU, 64'h1234_5678_9ABC_DEF0, SIZE_H,
                                      8'hFF, 8'hFF));
      directed.push_back(make_request(CMD_HEXL, 64'hFEDC_BA98_7654_3210, SIZE_UNUSED,
                                      8'd12, 8'd10));
      directed.push_back(make_request(CMD_DEC, 64'd123, SIZE_PLAIN, 8'd127, 8'hFF));
      directed.push_back(make_request(CMD_OCT, 64'd8, SIZE_PLAIN, 8'hFF, 8'd127));
      directed.push_back(make_request(CMD_DEC, 64'd42, SIZE_PLAIN, 8'd64, 8'd64));
      directed.push_back(make_request(CMD_HEXL, 64'hABC, SIZE_PLAIN, 8'h80, 8'h80));
      directed.push_back(make_request(CMD_DEC, 64'd0, SIZE_H, 8'd3, 8'h80));
      directed.push_back(make_request(CMD_DEC, 64'd7, SIZE_PLAIN, 8'd0, 8'd0));
      directed.push_back(make_request(CMD_HEXU, 64'hA, SIZE_L, 8'd65, 8'd66));
      directed.push_back(make_request(CMD_DEC, 64'h8000_0000_0000_0000, SIZE_L,
                                      8'd25, 8'd22));
      directed.push_back(make_request(CMD_OCT, 64'd7, SIZE_H, 8'd1, 8'd3));
      directed.push_back(make_request(CMD_DEC, 64'd0, SIZE_L, 8'd64, 8'd0));
      directed.push_back(make_request(CMD_HEXL, 64'h0000_0000_FFFF_0000, SIZE_H,
                                      8'hFF, 8'd0));
      foreach (directed[i]) send_request(directed[i]);

      // Random requests; one stretch runs with no idling on either side.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         burst_mode = (n >= 75 && n < 100);
         send_request(random_request());
      end
      burst_mode = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      // Wait for the last characters, then allow for a trailing empty item.
      while (board.owed_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.check_drained();
      if (board.failures == 0) begin
         $display("** unsigned_radix_text_formatter: PASSED **");
      end else begin
         $display("** unsigned_radix_text_formatter: FAILED **");
      end
      $finish;
   end

endmodule
